// ----- src/yfu_pkg.sv -----
package yfu_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int ROW_WIDTH_W   = 13;
    localparam int LAYOUT_W      = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;
    localparam int PIX_COL_W     = 12;
    localparam int NUM_SLOTS     = 6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LAYOUT = 1'd1;

    typedef enum logic [LAYOUT_W-1:0] {
        LAYOUT_ARGB = 3'd0,
        LAYOUT_RGBA = 3'd1,
        LAYOUT_BGRA = 3'd2,
        LAYOUT_RGB  = 3'd3,
        LAYOUT_BGR  = 3'd4
    } layout_t;

    typedef struct packed {
        logic [7:0] upper_u;
        logic [7:0] upper_v;
        logic [7:0] here_u;
        logic [7:0] here_v;
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_top_extra;
        logic [7:0] luma_bot_left;
        logic [7:0] luma_bot_right;
        logic [7:0] luma_bot_extra;
        logic       has_bottom;
    } item_word_t;

    typedef struct packed {
        logic [7:0]           byte0;
        logic [7:0]           byte1;
        logic [7:0]           byte2;
        logic [7:0]           byte3;
        logic                 on_bottom_row;
        logic [PIX_COL_W-1:0] pixel_column;
        logic                 last_of_run;
    } pixel_word_t;

    // One pixel position of a chroma column, before color conversion
    typedef struct packed {
        logic                 valid;
        logic                 bottom;
        logic [PIX_COL_W-1:0] col;
        logic [7:0]           y;
        logic [7:0]           u;
        logic [7:0]           v;
    } slot_t;

    // One converted pixel out of a lane
    typedef struct packed {
        logic                 valid;
        logic                 bottom;
        logic [PIX_COL_W-1:0] col;
        logic [7:0]           r;
        logic [7:0]           g;
        logic [7:0]           b;
    } lane_pix_t;

endpackage

// ----- src/yfu_front.sv -----
module yfu_front
    import yfu_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   drain,
    input  item_word_t             item,
    input  logic [ROW_WIDTH_W-1:0] row_width,
    output logic                   a_valid,
    output slot_t                  slots [NUM_SLOTS]
);

    localparam int XW = $clog2(MAX_WIDTH);

    // 9-3-3-1 filter: returns {top 2x-1, top 2x, bottom 2x-1, bottom 2x}
    function automatic logic [31:0] diag(input logic [7:0] p, input logic [7:0] t,
                                         input logic [7:0] q, input logic [7:0] c);
        logic [10:0] avg;
        logic [9:0]  sum_tq;
        logic [9:0]  sum_pc;
        logic [11:0] s12;
        logic [11:0] s03;
        logic [9:0]  o0;
        logic [9:0]  o1;
        logic [9:0]  b0;
        logic [9:0]  b1;
        avg    = 11'(p) + 11'(t) + 11'(q) + 11'(c) + 11'd8;
        sum_tq = 10'(t) + 10'(q);
        sum_pc = 10'(p) + 10'(c);
        s12    = 12'(avg) + 12'({sum_tq, 1'b0});
        s03    = 12'(avg) + 12'({sum_pc, 1'b0});
        o0     = 10'(s12[11:3]) + 10'(p);
        o1     = 10'(s03[11:3]) + 10'(t);
        b0     = 10'(s03[11:3]) + 10'(q);
        b1     = 10'(s12[11:3]) + 10'(c);
        return {o0[8:1], o1[8:1], b0[8:1], b1[8:1]};
    endfunction

    function automatic logic [7:0] edge_filt(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] s;
        s = 10'({a, 1'b0}) + 10'(a) + 10'(b) + 10'd2;
        return s[9:2];
    endfunction

    logic [ROW_WIDTH_W-1:0] w_eff;
    logic [PIX_COL_W-1:0]   last_col;
    logic [XW-1:0]          last_x;
    logic [XW-1:0]          x;
    logic [XW:0]            x2;
    logic                   is_last;
    logic                   first;
    logic                   extra;
    logic                   bot;
    logic [31:0]            diag_u;
    logic [31:0]            diag_v;
    logic [7:0]             edge_tu;
    logic [7:0]             edge_tv;
    logic [7:0]             edge_cu;
    logic [7:0]             edge_cv;
    logic [PIX_COL_W-1:0]   col_odd;
    logic [PIX_COL_W-1:0]   col_even;
    logic [PIX_COL_W-1:0]   col_extra;

    logic [XW-1:0]          col_reg;
    logic [XW-1:0]          col_next;
    logic [7:0]             prev_tu_reg;
    logic [7:0]             prev_tv_reg;
    logic [7:0]             prev_cu_reg;
    logic [7:0]             prev_cv_reg;
    logic                   a_valid_reg;
    logic                   a_valid_next;
    slot_t                  slot_reg  [NUM_SLOTS];
    slot_t                  slot_next [NUM_SLOTS];

    always_comb
    begin
        if (row_width == '0)
            w_eff = ROW_WIDTH_W'(1);
        else if (32'(row_width) > MAX_WIDTH)
            w_eff = ROW_WIDTH_W'(MAX_WIDTH);
        else
            w_eff = row_width;
        last_col = PIX_COL_W'((w_eff - ROW_WIDTH_W'(1)) >> 1);
        last_x   = XW'(last_col);
        x        = (col_reg > last_x) ? last_x : col_reg;
        x2       = {x, 1'b0};
        is_last  = (x == last_x);
        first    = (x == '0);
        extra    = is_last && !w_eff[0];
        bot      = item.has_bottom;
        col_even  = PIX_COL_W'(x2);
        col_odd   = PIX_COL_W'(x2 - (XW+1)'(1));
        col_extra = PIX_COL_W'(x2 | (XW+1)'(1));
        col_next  = is_last ? '0 : x + XW'(1);
    end

    always_comb
    begin
        diag_u  = diag(prev_tu_reg, item.upper_u, prev_cu_reg, item.here_u);
        diag_v  = diag(prev_tv_reg, item.upper_v, prev_cv_reg, item.here_v);
        edge_tu = edge_filt(item.upper_u, item.here_u);
        edge_tv = edge_filt(item.upper_v, item.here_v);
        edge_cu = edge_filt(item.here_u, item.upper_u);
        edge_cv = edge_filt(item.here_v, item.upper_v);

        // Column 0 puts its single pixel pair in the 2x positions
        slot_next[0] = '{valid: !first, bottom: 1'b0, col: col_odd,
                         y: item.luma_top_left, u: diag_u[31:24], v: diag_v[31:24]};
        slot_next[1] = '{valid: 1'b1, bottom: 1'b0, col: col_even,
                         y: item.luma_top_right,
                         u: first ? edge_tu : diag_u[23:16],
                         v: first ? edge_tv : diag_v[23:16]};
        slot_next[2] = '{valid: !first && bot, bottom: 1'b1, col: col_odd,
                         y: item.luma_bot_left, u: diag_u[15:8], v: diag_v[15:8]};
        slot_next[3] = '{valid: bot, bottom: 1'b1, col: col_even,
                         y: item.luma_bot_right,
                         u: first ? edge_cu : diag_u[7:0],
                         v: first ? edge_cv : diag_v[7:0]};
        slot_next[4] = '{valid: extra, bottom: 1'b0, col: col_extra,
                         y: item.luma_top_extra, u: edge_tu, v: edge_tv};
        slot_next[5] = '{valid: extra && bot, bottom: 1'b1, col: col_extra,
                         y: item.luma_bot_extra, u: edge_cu, v: edge_cv};
    end

    always_comb
    begin
        if (take)
            a_valid_next = 1'b1;
        else if (drain)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            prev_tu_reg <= '0;
            prev_tv_reg <= '0;
            prev_cu_reg <= '0;
            prev_cv_reg <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (take)
            begin
                col_reg     <= col_next;
                prev_tu_reg <= item.upper_u;
                prev_tv_reg <= item.upper_v;
                prev_cu_reg <= item.here_u;
                prev_cv_reg <= item.here_v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            slot_reg <= slot_next;
    end

    assign a_valid = a_valid_reg;
    assign slots   = slot_reg;

    // A finished row always restarts at column zero
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_last) |=> (col_reg == '0))
        else $error("column did not wrap at row end");

endmodule

// ----- src/yfu_lane.sv -----
module yfu_lane
    import yfu_pkg::*;
(
    input  logic      clk,
    input  logic      load,
    input  slot_t     slot,
    output lane_pix_t pix
);

    localparam int K_Y     = 19077;
    localparam int K_VR    = 26149;
    localparam int K_UG    = 6419;
    localparam int K_VG    = 13320;
    localparam int K_UB    = 33050;
    localparam int OFF_R   = 14234;
    localparam int OFF_G   = 8708;
    localparam int OFF_B   = 17685;

    function automatic logic [7:0] clip6(input logic signed [17:0] s);
        if (s[17:14] == 4'd0)
            return s[13:6];
        else if (s[17])
            return 8'd0;
        else
            return 8'hff;
    endfunction

    logic [23:0] yy_prod;
    logic [23:0] vr_prod;
    logic [23:0] ug_prod;
    logic [23:0] vg_prod;
    logic [23:0] ub_prod;

    logic [15:0]          yy_reg;
    logic [15:0]          vr_reg;
    logic [15:0]          ug_reg;
    logic [15:0]          vg_reg;
    logic [15:0]          ub_reg;
    logic                 valid_reg;
    logic                 bottom_reg;
    logic [PIX_COL_W-1:0] col_reg;

    logic signed [17:0] r_sum;
    logic signed [17:0] g_sum;
    logic signed [17:0] b_sum;

    assign yy_prod = 24'(slot.y) * 24'(K_Y);
    assign vr_prod = 24'(slot.v) * 24'(K_VR);
    assign ug_prod = 24'(slot.u) * 24'(K_UG);
    assign vg_prod = 24'(slot.v) * 24'(K_VG);
    assign ub_prod = 24'(slot.u) * 24'(K_UB);

    // Hold the scaled terms; the sums and clip follow from registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            yy_reg     <= yy_prod[23:8];
            vr_reg     <= vr_prod[23:8];
            ug_reg     <= ug_prod[23:8];
            vg_reg     <= vg_prod[23:8];
            ub_reg     <= ub_prod[23:8];
            valid_reg  <= slot.valid;
            bottom_reg <= slot.bottom;
            col_reg    <= slot.col;
        end
    end

    always_comb
    begin
        r_sum = 18'(yy_reg) + 18'(vr_reg) - 18'(OFF_R);
        g_sum = 18'(yy_reg) - 18'(ug_reg) - 18'(vg_reg) + 18'(OFF_G);
        b_sum = 18'(yy_reg) + 18'(ub_reg) - 18'(OFF_B);
        pix.valid  = valid_reg;
        pix.bottom = bottom_reg;
        pix.col    = col_reg;
        pix.r      = clip6(r_sum);
        pix.g      = clip6(g_sum);
        pix.b      = clip6(b_sum);
    end

endmodule

// ----- src/yfu_merge.sv -----
module yfu_merge
    import yfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  lane_pix_t   lanes [NUM_SLOTS],
    input  layout_t     layout,
    input  logic        pixel_stall,
    output logic        pixel_valid,
    output pixel_word_t pixel_word,
    output logic        free
);

    localparam int SEL_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;
    logic [NUM_SLOTS-1:0] load_mask;
    logic [NUM_SLOTS-1:0] sel_oh;
    logic [NUM_SLOTS-1:0] rest;
    logic [SEL_W-1:0]     sel;
    logic                 taken;
    lane_pix_t            buf_reg [NUM_SLOTS];
    lane_pix_t            cur;

    always_comb
    begin
        sel    = '0;
        sel_oh = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel    = SEL_W'(i);
                sel_oh = NUM_SLOTS'(1) << i;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            load_mask[i] = lanes[i].valid;
        rest        = mask_reg & ~sel_oh;
        pixel_valid = (mask_reg != '0);
        taken       = pixel_valid && !pixel_stall;
        free        = !pixel_valid || (taken && (rest == '0));
        if (load)
            mask_next = load_mask;
        else if (taken)
            mask_next = rest;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= lanes;
    end

    always_comb
    begin
        cur = buf_reg[sel];
        pixel_word.on_bottom_row = cur.bottom;
        pixel_word.pixel_column  = cur.col;
        pixel_word.last_of_run   = (rest == '0);
        unique case (layout)
            LAYOUT_RGBA:
            begin
                pixel_word.byte0 = cur.r;
                pixel_word.byte1 = cur.g;
                pixel_word.byte2 = cur.b;
                pixel_word.byte3 = 8'hff;
            end
            LAYOUT_BGRA:
            begin
                pixel_word.byte0 = cur.b;
                pixel_word.byte1 = cur.g;
                pixel_word.byte2 = cur.r;
                pixel_word.byte3 = 8'hff;
            end
            LAYOUT_RGB:
            begin
                pixel_word.byte0 = cur.r;
                pixel_word.byte1 = cur.g;
                pixel_word.byte2 = cur.b;
                pixel_word.byte3 = 8'h00;
            end
            LAYOUT_BGR:
            begin
                pixel_word.byte0 = cur.b;
                pixel_word.byte1 = cur.g;
                pixel_word.byte2 = cur.r;
                pixel_word.byte3 = 8'h00;
            end
            default:
            begin
                pixel_word.byte0 = 8'hff;
                pixel_word.byte1 = cur.r;
                pixel_word.byte2 = cur.g;
                pixel_word.byte3 = cur.b;
            end
        endcase
    end

    // A run continues after any word that is not its last
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && !pixel_word.last_of_run) |=> pixel_valid)
        else $error("run ended before its last word");

    // The buffer is only reloaded once the current run is used up
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && pixel_valid) |-> (taken && pixel_word.last_of_run))
        else $error("buffer reloaded over pending words");

endmodule

// ----- src/yuv420_fancy_upsample_to_rgb.sv -----
// Pipeline: a taken item passes the filter register, the lane product register and
//   the output buffer before its first pixel word is offered.
// Throughput: an item enters every cycle while the pipeline is free; the output
//   buffer drains one word per cycle while pixel_stall is low; an item yields 1 to 6
//   words (2 or 4 typical), all through the single output port.
// Reset (rst_n low, async): pipeline empty, row_width 1, ARGB, column 0, chroma 0.
module yuv420_fancy_upsample_to_rgb
    import yfu_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_word_t             item_word,

    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output pixel_word_t            pixel_word,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    layout_t                layout_reg;

    // Pipeline control: stage A holds filtered chroma per pixel position,
    // stage B holds the lane products, then the output buffer.
    logic      a_valid;
    logic      b_valid_reg;
    logic      b_valid_next;
    logic      b_ready;
    logic      buf_free;
    logic      item_take;
    logic      a_go;
    logic      buf_load;
    slot_t     slots [NUM_SLOTS];
    lane_pix_t lanes [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_W'(1);
            layout_reg    <= LAYOUT_ARGB;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:     row_width_reg <= cfg_data[ROW_WIDTH_W-1:0];
                REG_OUTPUT_LAYOUT: layout_reg    <= layout_t'(cfg_data[LAYOUT_W-1:0]);
                default:           ;
            endcase
        end
    end

    // Advance a stage when it is empty or the one behind it moves on
    always_comb
    begin
        buf_load     = b_valid_reg && buf_free;
        b_ready      = !b_valid_reg || buf_free;
        a_go         = a_valid && b_ready;
        item_stall   = a_valid && !b_ready;
        item_take    = item_valid && !item_stall;
        if (b_ready)
            b_valid_next = a_valid;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    // Column tracking and chroma filter for all six pixel positions
    yfu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (item_take),
        .drain     (b_ready),
        .item      (item_word),
        .row_width (row_width_reg),
        .a_valid   (a_valid),
        .slots     (slots)
    );

    // One color converter per pixel position
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_lane
        yfu_lane u_lane (
            .clk  (clk),
            .load (a_go),
            .slot (slots[i]),
            .pix  (lanes[i])
        );
    end

    // Collect the lane results and send the valid ones in order
    yfu_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (buf_load),
        .lanes       (lanes),
        .layout      (layout_reg),
        .pixel_stall (pixel_stall),
        .pixel_valid (pixel_valid),
        .pixel_word  (pixel_word),
        .free        (buf_free)
    );

    // Hold stage B while the output buffer is still busy
    a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !buf_free) |=> b_valid_reg)
        else $error("stage B dropped a pending item");

endmodule
